FILE: sv/apb_pkg.sv
// Package for the articulation point and bridge finder.
// Holds opcode, result kind and controller command/status types; no dependencies.
package apb_pkg;
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [1:0] KIND_BRIDGE = 2'd0;
	localparam logic [1:0] KIND_ARTIC  = 2'd1;
	localparam logic [1:0] KIND_NONE   = 2'd2;

	localparam int MaxResults = 32;

	typedef struct packed {
		logic clear;      // zero degrees and overflow
		logic append;     // append to_vertex to from_vertex list
		logic init;       // begin a search from the root
		logic step;       // one search step (descend, scan or retreat)
		logic scan_init;  // begin articulation scan
		logic scan_step;  // one vertex of the articulation scan
		logic finish;     // send the held result, or none-found, with last
	} apb_cmd_t;

	typedef struct packed {
		logic stack_empty;  // search finished
		logic scan_done;    // articulation scan passed the last vertex
	} apb_sts_t;
endpackage

FILE: sv/apb_ctrl.sv
// Controller state machine of the articulation point and bridge finder.
// Depends on apb_pkg for command and status types.
module apb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  apb_pkg::apb_sts_t sts,
	output logic              busy,
	output apb_pkg::apb_cmd_t cmd
);
	import apb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_STEP  = 2'd2;
	localparam logic [1:0] ST_SCAN  = 2'd3;

	logic [1:0] state_q;
	logic       go;

	assign busy = (state_q != ST_IDLE);
	assign go   = start && !busy;

	always_comb begin
		cmd           = '0;
		cmd.clear     = go && (opcode == OP_CLEAR);
		cmd.append    = go && (opcode == OP_APPEND);
		cmd.init      = go && (opcode == OP_SEARCH);
		cmd.step      = (state_q == ST_STEP);
		cmd.scan_init = (state_q == ST_FETCH) && sts.stack_empty;
		cmd.scan_step = (state_q == ST_SCAN) && !sts.scan_done;
		cmd.finish    = (state_q == ST_SCAN) && sts.scan_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go && opcode == OP_SEARCH) state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= sts.stack_empty ? ST_SCAN : ST_STEP;
				end
				ST_STEP: state_q <= ST_FETCH;
				ST_SCAN: begin
					if (sts.scan_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.step, cmd.scan_step, cmd.finish, cmd.init, cmd.scan_init}))
		else $error("several phase commands at once");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !(cmd.clear || cmd.append || cmd.init))
		else $error("item accepted while busy");
	a_step_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |=> (state_q == ST_FETCH))
		else $error("step not followed by fetch");
endmodule

FILE: sv/apb_dpath.sv
// Datapath of the articulation point and bridge finder: adjacency memory,
// per-vertex search tables, DFS stack and result register. Depends on apb_pkg.
module apb_dpath #(
	parameter int VERTICES   = 16,
	parameter int MAX_DEGREE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  apb_pkg::apb_cmd_t cmd,
	input  logic [3:0]        from_vertex,
	input  logic [3:0]        to_vertex,
	input  logic [3:0]        root_vertex,
	output apb_pkg::apb_sts_t sts,
	output logic              result_valid,
	output logic [1:0]        kind,
	output logic [3:0]        vertex_a,
	output logic [3:0]        vertex_b,
	output logic              overflow,
	output logic              last
);
	import apb_pkg::*;

	localparam int VW    = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam int OW    = $clog2(VERTICES + 1);
	localparam int SW    = $clog2(VERTICES + 1);
	localparam int CW    = $clog2(MaxResults + 1);
	localparam int DEPTH = VERTICES * MAX_DEGREE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// adjacency is a memory read through a register; the controller passes its
	// fetch state before each step, so the entry is ready when the step runs.
	logic [3:0]    adj_mem [DEPTH];
	logic [3:0]    adj_rd_q;
	logic [DW-1:0] degree_q [VERTICES];
	logic [OW-1:0] order_q  [VERTICES];
	logic          visited_q [VERTICES];
	logic [OW-1:0] low_q    [VERTICES];
	logic [VW-1:0] parent_q [VERTICES];
	logic [VW-1:0] stk_v_q  [VERTICES];
	logic [DW-1:0] stk_e_q  [VERTICES];
	logic [SW-1:0] sp_q;
	logic [OW-1:0] ctr_q;
	logic [1:0]    root_kids_q;
	logic [VERTICES-1:0] mark_q;
	logic          ovf_q;
	logic [CW-1:0] nres_q;
	logic [VW:0]   scan_q;
	logic          root_ok_q;
	logic [VW-1:0] root_q;
	// one result is held back so the final one can carry last
	logic          pend_v_q;
	logic [1:0]    pend_kind_q;
	logic [3:0]    pend_a_q;
	logic [3:0]    pend_b_q;

	logic [VW-1:0] top_sp, par_sp, u, w, p;
	logic [DW-1:0] idx;
	logic          has_edge, w_valid, w_new, can_emit;
	logic [AW-1:0] rd_addr;

	assign top_sp   = VW'(sp_q - SW'(1));
	assign par_sp   = VW'(sp_q - SW'(2));
	assign u        = stk_v_q[top_sp];
	assign idx      = stk_e_q[top_sp];
	assign p        = stk_v_q[par_sp];
	assign has_edge = (idx < degree_q[u]);
	assign rd_addr  = AW'(u) * AW'(MAX_DEGREE) + AW'(idx);
	assign w_valid  = (32'(adj_rd_q) < VERTICES);
	assign w        = VW'(adj_rd_q);
	assign w_new    = w_valid && !visited_q[w];
	assign can_emit = (nres_q < CW'(MaxResults));

	assign sts.stack_empty = (sp_q == '0);
	assign sts.scan_done   = (scan_q == (VW+1)'(VERTICES));

	logic app_ok;
	assign app_ok = (32'(from_vertex) < VERTICES) && (32'(to_vertex) < VERTICES)
		&& (degree_q[VW'(from_vertex)] < DW'(MAX_DEGREE));

	always_ff @(posedge clk) begin
		if (cmd.append && app_ok)
			adj_mem[AW'(VW'(from_vertex)) * AW'(MAX_DEGREE)
				+ AW'(degree_q[VW'(from_vertex)])] <= to_vertex;
		adj_rd_q <= adj_mem[rd_addr];
	end

	logic final_mark_w;
	assign final_mark_w = (root_kids_q > 2'd1);

	// new bridge on a retreat, or new articulation point in the scan
	logic       new_v;
	logic [1:0] new_kind;
	logic [3:0] new_a, new_b;
	always_comb begin
		new_v    = 1'b0;
		new_kind = KIND_BRIDGE;
		new_a    = 4'(p);
		new_b    = 4'(u);
		if (cmd.step && !has_edge && sp_q > SW'(1) && low_q[u] > order_q[p])
			new_v = can_emit;
		if (cmd.scan_step && mark_q[VW'(scan_q)]) begin
			new_v    = can_emit;
			new_kind = KIND_ARTIC;
			new_a    = 4'(scan_q);
			new_b    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VERTICES; i++) begin
				degree_q[i]  <= '0;
				visited_q[i] <= 1'b0;
			end
			sp_q         <= '0;
			ctr_q        <= '0;
			root_kids_q  <= '0;
			mark_q       <= '0;
			ovf_q        <= 1'b0;
			nres_q       <= '0;
			scan_q       <= '0;
			root_ok_q    <= 1'b0;
			root_q       <= '0;
			pend_v_q     <= 1'b0;
			pend_kind_q  <= '0;
			pend_a_q     <= '0;
			pend_b_q     <= '0;
			result_valid <= 1'b0;
			kind         <= '0;
			vertex_a     <= '0;
			vertex_b     <= '0;
			last         <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			last         <= 1'b0;
			if (cmd.clear) begin
				for (int i = 0; i < VERTICES; i++) degree_q[i] <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.append) begin
				if (app_ok)
					degree_q[VW'(from_vertex)] <= degree_q[VW'(from_vertex)] + DW'(1);
				else
					ovf_q <= 1'b1;
			end
			if (cmd.init) begin
				for (int i = 0; i < VERTICES; i++) visited_q[i] <= 1'b0;
				root_kids_q <= '0;
				mark_q      <= '0;
				nres_q      <= '0;
				pend_v_q    <= 1'b0;
				root_ok_q   <= (32'(root_vertex) < VERTICES);
				root_q      <= VW'(root_vertex);
				if (32'(root_vertex) < VERTICES) begin
					visited_q[VW'(root_vertex)] <= 1'b1;
					order_q[VW'(root_vertex)]   <= '0;
					low_q[VW'(root_vertex)]     <= '0;
					parent_q[VW'(root_vertex)]  <= VW'(root_vertex);
					stk_v_q[0] <= VW'(root_vertex);
					stk_e_q[0] <= '0;
					sp_q  <= SW'(1);
					ctr_q <= OW'(1);
				end else begin
					sp_q  <= '0;
					ctr_q <= '0;
				end
			end
			if (cmd.step) begin
				if (has_edge) begin
					stk_e_q[top_sp] <= idx + DW'(1);
					if (w_new) begin
						parent_q[w]  <= u;
						visited_q[w] <= 1'b1;
						order_q[w]   <= ctr_q;
						low_q[w]     <= ctr_q;
						ctr_q        <= ctr_q + OW'(1);
						if (u == root_q && root_kids_q != 2'd3)
							root_kids_q <= root_kids_q + 2'd1;
						if (32'(sp_q) < VERTICES) begin
							stk_v_q[VW'(sp_q)] <= w;
							stk_e_q[VW'(sp_q)] <= '0;
							sp_q <= sp_q + SW'(1);
						end
					end else if (w_valid && w != parent_q[u]
							&& order_q[w] < low_q[u]) begin
						low_q[u] <= order_q[w];
					end
				end else begin
					sp_q <= sp_q - SW'(1);
					if (sp_q > SW'(1)) begin
						if (low_q[u] >= order_q[p]) mark_q[p] <= 1'b1;
						if (low_q[u] < low_q[p]) low_q[p] <= low_q[u];
					end
				end
			end
			if (cmd.scan_init) begin
				scan_q <= '0;
				if (root_ok_q) mark_q[root_q] <= final_mark_w;
			end
			if (cmd.scan_step)
				scan_q <= scan_q + (VW+1)'(1);
			// a new result releases the held one, which is then known not last
			if (new_v) begin
				result_valid <= pend_v_q;
				kind         <= pend_kind_q;
				vertex_a     <= pend_a_q;
				vertex_b     <= pend_b_q;
				pend_v_q     <= 1'b1;
				pend_kind_q  <= new_kind;
				pend_a_q     <= new_a;
				pend_b_q     <= new_b;
				nres_q       <= nres_q + CW'(1);
			end
			if (cmd.finish) begin
				result_valid <= 1'b1;
				last         <= 1'b1;
				kind         <= pend_v_q ? pend_kind_q : KIND_NONE;
				vertex_a     <= pend_v_q ? pend_a_q : 4'd0;
				vertex_b     <= pend_v_q ? pend_b_q : 4'd0;
				pend_v_q     <= 1'b0;
			end
		end
	end

	assign overflow = ovf_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= VERTICES) else $error("stack pointer out of range");
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(nres_q) <= MaxResults) else $error("result count over limit");
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> result_valid) else $error("last without strobe");
endmodule

FILE: sv/articulation_points_and_bridges.sv
// Top level of the articulation point and bridge finder.
// Instantiates apb_ctrl and apb_dpath; uses apb_pkg.
//
// Commands: start with opcode 0 (clear), 1 (append from_vertex->to_vertex)
// or 2 (search from the root register). Clear and append do not raise
// busy, so loads go in every cycle while the block is idle. A search keeps
// busy high while it runs: every DFS step (each adjacency entry scanned,
// each retreat) passes through a fetch state for the registered adjacency
// read and then an execute state; the fetch state then sees the empty stack,
// the articulation scan visits each vertex and the final item is sent.
// Results appear as one-cycle strobes on result_valid; the receiver cannot
// stall, so it must take each transaction as it comes. One result is held
// back so the final one can be marked, so the last transaction of a run
// (last high) comes in the same cycle as busy falls. Bridges come in
// discovery order, then articulation points in ascending order. The user
// must write the root register with root_wr_en only while the block is
// idle and no result is outstanding; the block itself does not enforce it.
module articulation_points_and_bridges #(
	parameter int VERTICES   = 16,
	parameter int MAX_DEGREE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [3:0] from_vertex,
	input  logic [3:0] to_vertex,
	input  logic       root_wr_en,
	input  logic [3:0] root_wr_data,
	output logic       result_valid,
	output logic [1:0] kind,
	output logic [3:0] vertex_a,
	output logic [3:0] vertex_b,
	output logic       overflow,
	output logic       last
);
	import apb_pkg::*;

	apb_cmd_t   cmd;
	apb_sts_t   sts;
	logic [3:0] root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_q <= '0;
		else if (root_wr_en) root_q <= root_wr_data;
	end

	apb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	apb_dpath #(
		.VERTICES   (VERTICES),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.from_vertex  (from_vertex),
		.to_vertex    (to_vertex),
		.root_vertex  (root_q),
		.sts          (sts),
		.result_valid (result_valid),
		.kind         (kind),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.overflow     (overflow),
		.last         (last)
	);
endmodule
